// ----- design/phone_pin_relay_controller_unit_defines.svh -----
// ----------------------------------------------------------------------------
// phone pin relay controller assertion macros
// Shared assertion forms for the checker of the relay controller.
// ----------------------------------------------------------------------------
`ifndef PHONE_PIN_RELAY_CONTROLLER_UNIT_DEFINES_SVH
`define PHONE_PIN_RELAY_CONTROLLER_UNIT_DEFINES_SVH

// checked on every edge out of reset
`define PPRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked only on edges where a result item is on offer
`define PPRC_ASSERT_OUT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> (prop)) \
		else $error(msg);

`endif

// ----- design/pprc_pkg.sv -----
// ----------------------------------------------------------------------------
// pprc_pkg
// Types, codes and constants of the phone pin relay controller.
// ----------------------------------------------------------------------------
package pprc_pkg;

	localparam int PIN_DIGITS = 4;
	localparam int PIN_SHOWN  = (PIN_DIGITS < 4) ? PIN_DIGITS : 4;
	localparam int ENTRY_IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

	typedef logic [3:0] digit_t;
	typedef digit_t [PIN_DIGITS-1:0] pin_arr_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_RING = 3'd1,
		MODE_AUTH = 3'd2,
		MODE_CTRL = 3'd3,
		MODE_PROG = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_RING   = 2'd1,
		CMD_BUTTON = 2'd2,
		CMD_DIGIT  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ANSWER_RINGS = 3'd0,
		REG_RING_GAP     = 3'd1,
		REG_SESSION      = 3'd2,
		REG_INIT_PIN     = 3'd3,
		REG_INIT_RELAYS  = 3'd4
	} reg_idx_t;

	localparam digit_t DTMF_ONE  = 4'd1;
	localparam digit_t DTMF_TWO  = 4'd2;
	localparam digit_t DTMF_FOUR = 4'd4;
	localparam digit_t DTMF_FIVE = 4'd5;
	localparam digit_t DTMF_ZERO = 4'd10;
	localparam digit_t DTMF_STAR = 4'd11;

	localparam logic [3:0]  RST_ANSWER_RINGS = 4'd4;
	localparam logic [15:0] RST_RING_GAP     = 16'd5000;
	localparam logic [15:0] RST_SESSION      = 16'd10000;
	localparam logic [15:0] RST_INIT_PIN     = 16'd0;
	localparam logic [1:0]  RST_INIT_RELAYS  = 2'd0;

	localparam logic [8:0] GREET_MS = 9'd500;
	localparam logic [8:0] PROG_MS  = 9'd200;
	localparam logic [8:0] CTRL_MS  = 9'd100;

	localparam logic [3:0] COUNT_MAX   = 4'd15;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	typedef struct packed {
		logic        relay_one;
		logic        relay_two;
		logic        off_hook;
		logic [2:0]  beep_count;
		logic [8:0]  beep_ms;
		logic        relays_store;
		logic        pin_store;
		logic [15:0] pin_value;
		logic [2:0]  mode;
	} result_t;

	// unpack register word into pin digits, digits past the fourth read zero
	function automatic pin_arr_t load_pin(input logic [15:0] pin);
		pin_arr_t p;
		p = '0;
		for (int i = 0; i < PIN_SHOWN; i++) begin
			p[i] = 4'(pin >> (4 * i));
		end
		return p;
	endfunction

	function automatic logic [15:0] pack_pin(input pin_arr_t p);
		logic [15:0] v;
		v = '0;
		for (int i = 0; i < PIN_SHOWN; i++) begin
			v = v | (16'(p[i]) << (4 * i));
		end
		return v;
	endfunction

endpackage

// ----- design/phone_pin_relay_controller_unit.sv -----
// ----------------------------------------------------------------------------
// phone_pin_relay_controller_unit
// Event driven answering controller: ring counting, pin check, relay control
// and pin programming, one result item for every event item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  in       | in        | in_valid / in_stall     | command, digit
//  out      | out       | out_valid / out_stall   | relay_one .. mode
//  cfg      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// an item is registered in the input register on acceptance and its result in the result register
// one item is taken every cycle while out_stall is low, set by the single pass between the two registers
// out_stall holds the result register; the input register then fills and
// in_stall rises only while both are occupied
// arst_n restores control state, registers, pin and relays to their reset values
// cfg_ready is always high; writes are meant for idle periods only
module phone_pin_relay_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  digit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        relay_one,
	output logic        relay_two,
	output logic        off_hook,
	output logic [2:0]  beep_count,
	output logic [8:0]  beep_ms,
	output logic        relays_store,
	output logic        pin_store,
	output logic [15:0] pin_value,
	output logic [2:0]  mode,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import pprc_pkg::*;

	// input stage
	logic       valid_s1;
	cmd_t       command_s1;
	digit_t     digit_s1;

	// result stage
	logic       valid_s2;
	result_t    res_s2;

	// controller state
	mode_t      mode_q;
	logic [3:0] count_q;
	logic [15:0] elapsed_q;
	pin_arr_t   entry_q;
	pin_arr_t   pin_q;
	logic [1:0] relay_q;

	// configuration
	logic [3:0]  answer_q;
	logic [15:0] ring_gap_q;
	logic [15:0] session_q;

	logic in_take;
	logic step;
	logic cfg_take;

	mode_t      mode_n;
	logic [3:0] count_n;
	logic [15:0] elapsed_n;
	pin_arr_t   entry_n;
	pin_arr_t   pin_n;
	logic [1:0] relay_n;
	logic [2:0] beep_n;
	logic [8:0] beep_len_n;
	logic       rstore_n;
	logic       pstore_n;
	result_t    res_n;

	assign step      = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall  = valid_s1 && !step;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1 <= cmd_t'(command);
			digit_s1   <= digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_n;
		end
	end

	// next state for one event
	always_comb begin
		mode_t      cur;
		logic [3:0] cnt;
		logic [15:0] elap;
		logic [15:0] elap_inc;
		logic [3:0] ring_cnt;
		logic       numeric;
		logic       take;

		cur  = mode_q;
		cnt  = count_q;
		elap = elapsed_q;
		if (!(mode_q == MODE_IDLE || mode_q == MODE_RING || mode_q == MODE_AUTH ||
				mode_q == MODE_CTRL || mode_q == MODE_PROG)) begin
			cur  = MODE_IDLE;
			cnt  = '0;
			elap = '0;
		end
		elap_inc = (elap == ELAPSED_MAX) ? elap : elap + 16'd1;
		numeric  = (digit_s1 >= DTMF_ONE) && (digit_s1 <= DTMF_ZERO);
		ring_cnt = (cur == MODE_IDLE) ? 4'd0 : cnt;
		ring_cnt = (ring_cnt < COUNT_MAX) ? ring_cnt + 4'd1 : ring_cnt;
		take     = 1'b0;

		mode_n     = cur;
		count_n    = cnt;
		elapsed_n  = elap;
		entry_n    = entry_q;
		pin_n      = pin_q;
		relay_n    = relay_q;
		beep_n     = '0;
		beep_len_n = '0;
		rstore_n   = 1'b0;
		pstore_n   = 1'b0;

		unique case (cur)
			MODE_IDLE, MODE_RING: begin
				unique case (command_s1)
					CMD_TICK: begin
						if (cur == MODE_RING) begin
							elapsed_n = elap_inc;
							if (elap_inc >= ring_gap_q) begin
								mode_n    = MODE_IDLE;
								count_n   = '0;
								elapsed_n = '0;
							end
						end
					end
					CMD_RING: begin
						mode_n    = MODE_RING;
						count_n   = ring_cnt;
						elapsed_n = '0;
						if (ring_cnt > answer_q) begin
							mode_n     = MODE_AUTH;
							count_n    = '0;
							beep_n     = 3'd1;
							beep_len_n = GREET_MS;
						end
					end
					CMD_BUTTON: begin
						mode_n     = MODE_PROG;
						count_n    = '0;
						elapsed_n  = '0;
						beep_n     = 3'd2;
						beep_len_n = PROG_MS;
					end
					default: begin
					end
				endcase
			end
			MODE_AUTH, MODE_PROG: begin
				if (command_s1 == CMD_TICK) begin
					elapsed_n = elap_inc;
					if (elap_inc >= session_q) begin
						mode_n    = MODE_IDLE;
						count_n   = '0;
						elapsed_n = '0;
					end
				end else if (cur == MODE_PROG && command_s1 == CMD_BUTTON) begin
					mode_n    = MODE_IDLE;
					count_n   = '0;
					elapsed_n = '0;
				end else if (command_s1 == CMD_DIGIT) begin
					if (cur == MODE_AUTH && digit_s1 == DTMF_STAR) begin
						mode_n    = MODE_IDLE;
						count_n   = '0;
						elapsed_n = '0;
					end else if (numeric) begin
						if (cnt < 4'(PIN_DIGITS)) begin
							entry_n[cnt[ENTRY_IDX_W-1:0]] = digit_s1;
							count_n = cnt + 4'd1;
						end
						take = (count_n >= 4'(PIN_DIGITS));
					end
				end
				if (take && cur == MODE_AUTH) begin
					if (entry_n == pin_q) begin
						mode_n     = MODE_CTRL;
						count_n    = '0;
						beep_n     = 3'd1;
						beep_len_n = GREET_MS;
					end else begin
						mode_n    = MODE_IDLE;
						count_n   = '0;
						elapsed_n = '0;
					end
				end
				if (take && cur == MODE_PROG) begin
					pin_n      = entry_n;
					pstore_n   = 1'b1;
					beep_n     = 3'd2;
					beep_len_n = PROG_MS;
					mode_n     = MODE_IDLE;
					count_n    = '0;
					elapsed_n  = '0;
				end
			end
			MODE_CTRL: begin
				if (command_s1 == CMD_TICK) begin
					elapsed_n = elap_inc;
					if (elap_inc >= session_q) begin
						mode_n    = MODE_IDLE;
						count_n   = '0;
						elapsed_n = '0;
					end
				end else if (command_s1 == CMD_DIGIT) begin
					elapsed_n = '0;
					unique case (digit_s1)
						DTMF_ONE: begin
							relay_n    = relay_q | 2'b01;
							rstore_n   = 1'b1;
							beep_n     = 3'd1;
							beep_len_n = CTRL_MS;
						end
						DTMF_TWO: begin
							relay_n    = relay_q & 2'b10;
							rstore_n   = 1'b1;
							beep_n     = 3'd2;
							beep_len_n = CTRL_MS;
						end
						DTMF_FOUR: begin
							relay_n    = relay_q | 2'b10;
							rstore_n   = 1'b1;
							beep_n     = 3'd4;
							beep_len_n = CTRL_MS;
						end
						DTMF_FIVE: begin
							relay_n    = relay_q & 2'b01;
							rstore_n   = 1'b1;
							beep_n     = 3'd5;
							beep_len_n = CTRL_MS;
						end
						DTMF_STAR: begin
							mode_n  = MODE_IDLE;
							count_n = '0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// result item
	always_comb begin
		res_n.relay_one    = relay_n[0];
		res_n.relay_two    = relay_n[1];
		res_n.off_hook     = (mode_n == MODE_AUTH) || (mode_n == MODE_CTRL) ||
			(mode_n == MODE_PROG);
		res_n.beep_count   = beep_n;
		res_n.beep_ms      = beep_len_n;
		res_n.relays_store = rstore_n;
		res_n.pin_store    = pstore_n;
		res_n.pin_value    = pack_pin(pin_n);
		res_n.mode         = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			count_q    <= '0;
			elapsed_q  <= '0;
			pin_q      <= load_pin(RST_INIT_PIN);
			relay_q    <= RST_INIT_RELAYS;
			answer_q   <= RST_ANSWER_RINGS;
			ring_gap_q <= RST_RING_GAP;
			session_q  <= RST_SESSION;
		end else begin
			if (step) begin
				mode_q    <= mode_n;
				count_q   <= count_n;
				elapsed_q <= elapsed_n;
				pin_q     <= pin_n;
				relay_q   <= relay_n;
			end
			if (cfg_take) begin
				unique case (cfg_index)
					REG_ANSWER_RINGS: answer_q   <= cfg_data[3:0];
					REG_RING_GAP:     ring_gap_q <= cfg_data;
					REG_SESSION:      session_q  <= cfg_data;
					REG_INIT_PIN:     pin_q      <= load_pin(cfg_data);
					REG_INIT_RELAYS:  relay_q    <= cfg_data[1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// entry digits need no reset, always written before compared
	always_ff @(posedge clk) begin
		if (step) begin
			entry_q <= entry_n;
		end
	end

	assign out_valid    = valid_s2;
	assign relay_one    = res_s2.relay_one;
	assign relay_two    = res_s2.relay_two;
	assign off_hook     = res_s2.off_hook;
	assign beep_count   = res_s2.beep_count;
	assign beep_ms      = res_s2.beep_ms;
	assign relays_store = res_s2.relays_store;
	assign pin_store    = res_s2.pin_store;
	assign pin_value    = res_s2.pin_value;
	assign mode         = res_s2.mode;

endmodule

// ----- design/pprc_checker.sv -----
// ----------------------------------------------------------------------------
// pprc_checker
// Port level checks of the phone pin relay controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "phone_pin_relay_controller_unit_defines.svh"

module pprc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        relay_one,
	input logic        relay_two,
	input logic        off_hook,
	input logic [2:0]  beep_count,
	input logic [8:0]  beep_ms,
	input logic        relays_store,
	input logic        pin_store,
	input logic [15:0] pin_value,
	input logic [2:0]  mode
);
	import pprc_pkg::*;

	logic [35:0] res_bus;
	logic        hook_ok;
	logic        pin_store_ok;
	logic        relay_store_ok;

	assign res_bus = {relay_one, relay_two, off_hook, beep_count, beep_ms, relays_store,
		pin_store, pin_value, mode};
	assign hook_ok = off_hook == (mode == MODE_AUTH || mode == MODE_CTRL ||
		mode == MODE_PROG);
	assign pin_store_ok = !pin_store ||
		(mode == MODE_IDLE && beep_count == 3'd2 && beep_ms == PROG_MS);
	assign relay_store_ok = !relays_store || (mode == MODE_CTRL && beep_ms == CTRL_MS);

	// stalled result item holds
	`PPRC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(res_bus), "result item changed while stalled")
	`PPRC_ASSERT_OUT(a_hook_mode, hook_ok, "off_hook does not match mode")
	`PPRC_ASSERT_OUT(a_beep_len, (beep_count == 3'd0) == (beep_ms == 9'd0), "beep length without beeps")
	`PPRC_ASSERT_OUT(a_pin_store, pin_store_ok, "pin stored outside programming end")
	`PPRC_ASSERT_OUT(a_relay_store, relay_store_ok, "relay store outside control")

endmodule

bind phone_pin_relay_controller_unit pprc_checker u_pprc_checker (.*);
